// ----- rtl/dpbs_pkg.sv -----
// Shared types and constants for the binary64 power-by-squaring block.
// Used by dpbs_fpu and by the top level double_power_by_squaring.
`default_nettype none
package dpbs_pkg;

  localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_MAX      = 11'h7FF;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_RCP = 2'b10
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

endpackage
`default_nettype wire

// ----- rtl/dpbs_fpu.sv -----
// Multi-cycle binary64 unit: multiply (a*b) or reciprocal (1/a), shared
// normalize and round-to-nearest-even. Depends on dpbs_pkg.
`default_nettype none
module dpbs_fpu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dpbs_pkg::fpu_req_t req,
  input  wire logic [63:0]       a,
  input  wire logic [63:0]       b,
  output logic                   done,
  output logic [63:0]            res
);

  typedef enum logic [6:0] {
    F_IDLE   = 7'b0000001,
    F_MUL    = 7'b0000010,
    F_DNORM  = 7'b0000100,
    F_DIV    = 7'b0001000,
    F_NORM   = 7'b0010000,
    F_DENORM = 7'b0100000,
    F_ROUND  = 7'b1000000
  } fstate_t;

  fstate_t            state;
  logic [105:0]       acc;
  logic               stk;
  logic signed [13:0] ex;
  logic               sgn;
  logic [5:0]         cnt;
  logic [52:0]        ma;
  logic [52:0]        mb;
  logic [52:0]        rem;

  // Operand decode.
  logic [10:0] a_exp, b_exp;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  assign a_exp  = a[62:52];
  assign b_exp  = b[62:52];
  assign a_nan  = (a_exp == dpbs_pkg::EXP_MAX) && (a[51:0] != 52'd0);
  assign b_nan  = (b_exp == dpbs_pkg::EXP_MAX) && (b[51:0] != 52'd0);
  assign a_inf  = (a_exp == dpbs_pkg::EXP_MAX) && (a[51:0] == 52'd0);
  assign b_inf  = (b_exp == dpbs_pkg::EXP_MAX) && (b[51:0] == 52'd0);
  assign a_zero = (a[62:0] == 63'd0);
  assign b_zero = (b[62:0] == 63'd0);

  logic [10:0] a_eff, b_eff;
  assign a_eff = (a_exp == 11'd0) ? 11'd1 : a_exp;
  assign b_eff = (b_exp == 11'd0) ? 11'd1 : b_exp;

  // One 27x27 partial product per cycle.
  logic [26:0]  pp_x, pp_y;
  logic [53:0]  pp;
  logic [105:0] pp_sh;
  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        pp_x  = ma[26:0];
        pp_y  = mb[26:0];
      end
      2'd1: begin
        pp_x  = ma[26:0];
        pp_y  = {1'b0, mb[52:27]};
      end
      2'd2: begin
        pp_x  = {1'b0, ma[52:27]};
        pp_y  = mb[26:0];
      end
      default: begin
        pp_x  = {1'b0, ma[52:27]};
        pp_y  = {1'b0, mb[52:27]};
      end
    endcase
    pp = pp_x * pp_y;
    case (cnt[1:0])
      2'd0:    pp_sh = 106'(pp);
      2'd1:    pp_sh = 106'(pp) << 27;
      2'd2:    pp_sh = 106'(pp) << 27;
      default: pp_sh = 106'(pp) << 54;
    endcase
  end

  // One restoring division step.
  logic [53:0] r2;
  logic        qb;
  logic [52:0] rem_next;
  always_comb begin
    r2 = {rem, 1'b0};
    qb = (r2 >= {1'b0, ma});
    rem_next = qb ? 53'(r2 - {1'b0, ma}) : r2[52:0];
  end

  // Rounding.
  logic        rnd_inc;
  logic        rnd_st;
  logic [10:0] rnd_field;
  logic [62:0] rnd_mag;
  always_comb begin
    rnd_st    = (acc[51:0] != 52'd0) | stk;
    rnd_inc   = acc[52] & (rnd_st | acc[53]);
    rnd_field = acc[105] ? ex[10:0] : 11'd0;
    rnd_mag   = {rnd_field, acc[104:53]} + 63'(rnd_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (req.start) begin
            if (req.op == dpbs_pkg::OP_MUL) begin
              sgn <= a[63] ^ b[63];
              if (a_nan) begin
                res  <= a | dpbs_pkg::QUIET_BIT;
                done <= 1'b1;
              end else if (b_nan) begin
                res  <= b | dpbs_pkg::QUIET_BIT;
                done <= 1'b1;
              end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                res  <= dpbs_pkg::DEFAULT_NAN;
                done <= 1'b1;
              end else if (a_inf || b_inf) begin
                res  <= {a[63] ^ b[63], dpbs_pkg::EXP_MAX, 52'd0};
                done <= 1'b1;
              end else if (a_zero || b_zero) begin
                res  <= {a[63] ^ b[63], 63'd0};
                done <= 1'b1;
              end else begin
                ma    <= {a_exp != 11'd0, a[51:0]};
                mb    <= {b_exp != 11'd0, b[51:0]};
                ex    <= 14'(a_eff) + 14'(b_eff) - 14'sd1022;
                acc   <= '0;
                stk   <= 1'b0;
                cnt   <= '0;
                state <= F_MUL;
              end
            end else begin
              sgn <= a[63];
              if (a_zero) begin
                res  <= {a[63], dpbs_pkg::EXP_MAX, 52'd0};
                done <= 1'b1;
              end else if (a_nan) begin
                res  <= a | dpbs_pkg::QUIET_BIT;
                done <= 1'b1;
              end else if (a_inf) begin
                res  <= {a[63], 63'd0};
                done <= 1'b1;
              end else begin
                ma    <= {a_exp != 11'd0, a[51:0]};
                ex    <= 14'sd2046 - 14'(a_eff);
                acc   <= '0;
                stk   <= 1'b0;
                cnt   <= '0;
                rem   <= {2'b01, 51'd0};
                state <= F_DNORM;
              end
            end
          end
        end
        F_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd3) begin
            state <= F_NORM;
          end
        end
        F_DNORM: begin
          // A subnormal divisor is brought up to a leading one first.
          if (ma[52]) begin
            state <= F_DIV;
          end else begin
            ma <= {ma[51:0], 1'b0};
            ex <= ex + 14'sd1;
          end
        end
        F_DIV: begin
          rem          <= rem_next;
          acc[105:50]  <= {acc[104:50], qb};
          cnt          <= cnt + 6'd1;
          if (cnt == 6'd55) begin
            stk   <= (rem_next != 53'd0);
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (acc[105]) begin
            if (ex >= 14'sd2047) begin
              res   <= {sgn, dpbs_pkg::EXP_MAX, 52'd0};
              done  <= 1'b1;
              state <= F_IDLE;
            end else if (ex < 14'sd1) begin
              state <= F_DENORM;
            end else begin
              state <= F_ROUND;
            end
          end else begin
            acc <= {acc[104:0], 1'b0};
            ex  <= ex - 14'sd1;
          end
        end
        F_DENORM: begin
          if (ex == 14'sd1) begin
            state <= F_ROUND;
          end else if (ex < -14'sd120) begin
            // Far below the subnormal range: everything lands in the sticky bit.
            acc <= '0;
            stk <= 1'b1;
            ex  <= 14'sd1;
          end else begin
            stk <= stk | acc[0];
            acc <= {1'b0, acc[105:1]};
            ex  <= ex + 14'sd1;
          end
        end
        F_ROUND: begin
          // The carry out of the fraction steps the exponent, up to infinity.
          res   <= {sgn, rnd_mag};
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/double_power_by_squaring.sv -----
// Top level of the binary64 integer power block. Sequences the squaring
// loop over one shared dpbs_fpu. Depends on dpbs_pkg and dpbs_fpu.
//
// Raises a binary64 base to a signed 32-bit power, one word at a time. A zero
// exponent gives 1.0. Otherwise a negative exponent first costs one
// reciprocal (56 division steps plus operand normalization), and each step
// of the restarting squaring loop costs two multiplications on the shared
// unit, each made of four 27x27 partial products, normalize, round, issue
// and return, with further shift steps when subnormals must be shifted. The
// total therefore grows with the number of loop steps. The input is not
// ready while a word is in progress; the result waits in an output register.
`default_nettype none
module double_power_by_squaring (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // base_bits [63:0], exponent [95:64]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // power_bits [63:0]
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RCP      = 9'b000000010,
    S_WAIT_RCP = 9'b000000100,
    S_CHECK    = 9'b000001000,
    S_MUL_R    = 9'b000010000,
    S_WAIT_R   = 9'b000100000,
    S_MUL_O    = 9'b001000000,
    S_WAIT_O   = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t      state;
  logic [63:0] base;
  logic [63:0] r;
  logic [63:0] o;
  logic [31:0] m;
  logic [32:0] c;

  dpbs_pkg::fpu_req_t req;
  logic [63:0]        fpu_a;
  logic [63:0]        fpu_b;
  logic               fpu_done;
  logic [63:0]        fpu_res;

  logic [31:0] in_exp;
  assign in_exp   = s_tdata[95:64];
  assign s_tready = (state == S_IDLE);

  always_comb begin
    req.start = 1'b0;
    req.op    = dpbs_pkg::OP_MUL;
    fpu_a     = o;
    fpu_b     = o;
    case (state)
      S_RCP: begin
        req.start = 1'b1;
        req.op    = dpbs_pkg::OP_RCP;
        fpu_a     = base;
      end
      S_MUL_R: begin
        req.start = 1'b1;
        fpu_a     = r;
      end
      S_MUL_O: begin
        req.start = 1'b1;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  dpbs_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (fpu_a),
    .b    (fpu_b),
    .done (fpu_done),
    .res  (fpu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // A word leaving in the same cycle as a new one is loaded is handled
      // by the finish state alone.
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            base <= s_tdata[63:0];
            o    <= s_tdata[63:0];
            r    <= dpbs_pkg::ONE_BITS;
            c    <= 33'd1;
            // The two's complement negation of the most negative exponent
            // reads as 2^31 unsigned, which is its magnitude.
            m    <= in_exp[31] ? (32'd0 - in_exp) : in_exp;
            if (in_exp == 32'd0) begin
              state <= S_FINISH;
            end else if (in_exp[31]) begin
              state <= S_RCP;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_RCP: begin
          state <= S_WAIT_RCP;
        end
        S_WAIT_RCP: begin
          if (fpu_done) begin
            base  <= fpu_res;
            o     <= fpu_res;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (m == 32'd0) begin
            state <= S_FINISH;
          end else if ({1'b0, m} >= c) begin
            state <= S_MUL_R;
          end else begin
            o <= base;
            c <= 33'd1;
          end
        end
        S_MUL_R: begin
          state <= S_WAIT_R;
        end
        S_WAIT_R: begin
          if (fpu_done) begin
            r     <= fpu_res;
            state <= S_MUL_O;
          end
        end
        S_MUL_O: begin
          state <= S_WAIT_O;
        end
        S_WAIT_O: begin
          if (fpu_done) begin
            o     <= fpu_res;
            m     <= m - c[31:0];
            c     <= {c[31:0], 1'b0};
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= r;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_double_power_by_squaring.sv -----
// Testbench for double_power_by_squaring: drives base/exponent words over the input
// stream and checks every power word against a predictor built on real arithmetic.
// Depends on dpbs_pkg and the RTL of double_power_by_squaring.
`timescale 1ns / 100ps
`default_nettype none
module tb_double_power_by_squaring;

  localparam int CYCLE_LIMIT = 6000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // base_bits [63:0], exponent [95:64]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // power_bits [63:0]

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  double_power_by_squaring DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  class power_scoreboard;
    logic [63:0] pending_powers[$];

    // Restarting squaring loop, multiplications kept in the block's order.
    function automatic logic [63:0] power_of(logic [63:0] base, logic [31:0] expo);
      logic [31:0] mag;
      logic [63:0] left;
      logic [63:0] chunk;
      real b, r, o;
      if (expo == 32'd0) return dpbs_pkg::ONE_BITS;
      mag = expo[31] ? -expo : expo;
      left = {32'd0, mag};
      b = $bitstoreal(base);
      if (expo[31]) begin
        if (base[62:0] == 63'd0) b = $bitstoreal({base[63], dpbs_pkg::EXP_MAX, 52'd0});
        else b = 1.0 / b;
      end
      r = 1.0;
      o = b;
      chunk = 64'd1;
      while (left > 0) begin
        if (left >= chunk) begin
          r = r * o;
          left = left - chunk;
          chunk = chunk << 1;
          o = o * o;
        end else begin
          o = b;
          chunk = 64'd1;
        end
      end
      return $realtobits(r);
    endfunction

    function void note_input(logic [95:0] word);
      pending_powers.push_back(power_of(word[63:0], word[95:64]));
    endfunction

    // Returns 1 on a mismatch; want holds the expected value, if any.
    function bit check_power(logic [63:0] got, output logic [63:0] want, output bit orphan);
      orphan = (pending_powers.size() == 0);
      want = 64'hx;
      if (orphan) return 1'b1;
      want = pending_powers.pop_front();
      return got !== want;
    endfunction
  endclass

  power_scoreboard sb;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    logic [63:0] want;
    bit orphan;
    cycle_count <= cycle_count + 1;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (sb.check_power(m_tdata, want, orphan))
        report(orphan ? "unexpected word" : "power_bits", m_tdata, want);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(logic [63:0] base, logic [31:0] expo);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {expo, base};
    do @(posedge clk); while (!s_tready);
    sb.note_input({expo, base});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_powers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_base();
    int unsigned pick;
    logic [63:0] v;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 55) v[62:52] = 11'h3FF + 11'($urandom_range(8)) - 11'd4;
    else if (pick < 65) v[62:52] = 11'd0;
    else if (pick < 72) v[62:0] = {dpbs_pkg::EXP_MAX, 52'd0};
    else if (pick < 76) v[62:0] = 63'd0;
    return v;
  endfunction

  function automatic logic [31:0] random_expo();
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    if (pick < 80) v = $urandom_range(40);
    else if (pick < 92) v = $urandom_range(5000);
    else v = $urandom;
    if (pick < 92 && $urandom_range(1)) v = -v;
    return v;
  endfunction

  initial begin
    logic [63:0] dir_base[12];
    logic [31:0] dir_expo[12];
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 16;
    recv_stall_pct = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero exponent with NaN and infinite bases, signed zeros under negative powers,
    // the most negative exponent, extremes of the base and the exponent.
    dir_base = '{64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0000,
                 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0001, 64'hBFF0_0000_0000_0000,
                 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h4000_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
    dir_expo = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'd2, 32'd1, 32'd3, 32'hFFFF_FC00, 32'h8000_0001, 32'd0};
    foreach (dir_base[i]) send_word(dir_base[i], dir_expo[i]);
    send_word(64'h3FF0_0000_0000_0000, 32'h8000_0000);
    send_word(64'h0000_0000_0000_0000, 32'd5);
    send_word(64'h7FF0_0000_0000_0000, 32'hFFFF_FFFE);

    // Hold the input until the block has handed back everything.
    drain();

    for (int n = 0; n < 140; n++) begin
      if (n == 47) begin
        send_idle_pct = 50;
        recv_stall_pct = 16;
      end else if (n == 94) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_word(random_base(), random_expo());
    end
    drain();
    repeat (200) @(posedge clk);

    if (error_count == 0 && sb.pending_powers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- double_power_by_squaring.f -----
rtl/dpbs_pkg.sv
rtl/dpbs_fpu.sv
rtl/double_power_by_squaring.sv
test/tb_double_power_by_squaring.sv
